### src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### src/sha1h_pkg.sv
// Package: types, constants and round helpers for the SHA-1 stream hasher
package sha1h_pkg;
    localparam int WordW = 32;
    localparam int BlkDepth = 16;
    localparam int BlkAw = 4;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PadByte = 8'h80;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_PAD,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_CLR,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    function automatic logic [31:0] rotl1(input logic [31:0] v);
        return {v[30:0], v[31]};
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] r;
        if (t < 7'd20)      r = (b & c) | (~b & d);
        else if (t < 7'd40) r = b ^ c ^ d;
        else if (t < 7'd60) r = (b & c) | (b & d) | (c & d);
        else                r = b ^ c ^ d;
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] r;
        if (t < 7'd20)      r = K0;
        else if (t < 7'd40) r = K1;
        else if (t < 7'd60) r = K2;
        else                r = K3;
        return r;
    endfunction
endpackage

### src/sha1h_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read
module sha1h_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/sha1_stream_hasher_core.sv
// Top level: byte-stream SHA-1 hasher built around a block-word RAM
// Steps: a byte is accepted and its word read, then the merged word written; a 64th byte
// also compresses the block (load, rounds, fold). A final item runs pad, clear, length, load,
// rounds, fold and out, compressing twice with an extra padding block; the digest then waits
// in an output register until taken. One item at a time; input keeps flowing while it waits.
// Reset (rst_n low, asynchronous): chaining words to initial values, counts cleared.
module sha1_stream_hasher_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] msg_byte
    input  logic         s_axis_tuser,   // [0] byte_present
    input  logic         s_axis_tlast,   // end_of_message
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata    // digest_word0 .. digest_word4, lowest first
);
    import sha1h_pkg::*;

    state_t state_reg, state_next;

    // chaining and working variables
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [7:0]  byte_reg;
    logic        pres_reg, last_reg;
    logic        second_reg;      // a second (length) compression still pending
    logic        fin_reg;         // current compression belongs to the final item
    logic [6:0]  t_reg;           // round / sweep counter
    logic [31:0] w_reg [16];      // message schedule window, w_reg[15] is w[t-1]
    logic [31:0] wr_word_reg;     // last merged word, forwarded to the pad step
    logic        out_valid_reg;
    logic [159:0] out_reg;

    // block RAM port
    logic              we;
    logic [BlkAw-1:0]  waddr, raddr;
    logic [31:0]       wdata, rdata;

    sha1h_ram #(.Width(WordW), .Depth(BlkDepth)) u_blk (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic        accept;
    logic        out_free;
    logic [1:0]  lane;
    logic [31:0] merged, padded, pad_src;
    logic [31:0] tmp, wn, w_cur;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    // the output register can take a new digest this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign lane = fill_reg[1:0];
    // a byte written just before padding is not yet visible on the read port
    assign pad_src = pres_reg ? wr_word_reg : rdata;

    // merge one byte into the word read back, big-endian lanes
    always_comb
    begin
        merged = rdata;
        unique case (lane)
            2'd0: merged[31:24] = byte_reg;
            2'd1: merged[23:16] = byte_reg;
            2'd2: merged[15:8]  = byte_reg;
            2'd3: merged[7:0]   = byte_reg;
            default: merged = rdata;
        endcase
        // pad word: keep message bytes, 0x80, zeros after
        unique case (lane)
            2'd0: padded = {PadByte, 24'd0};
            2'd1: padded = {pad_src[31:24], PadByte, 16'd0};
            2'd2: padded = {pad_src[31:16], PadByte, 8'd0};
            2'd3: padded = {pad_src[31:8], PadByte};
            default: padded = pad_src;
        endcase
    end

    // w[t] streams from the RAM for the first 16 rounds, then from the window
    assign wn    = rotl1(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]);
    assign w_cur = (t_reg < 7'd16) ? rdata : wn;
    assign tmp   = {a_reg[26:0], a_reg[31:27]} + round_f(t_reg, b_reg, c_reg, d_reg)
                 + e_reg + round_k(t_reg) + w_cur;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = s_axis_tuser ? ST_WRITE
                               : (s_axis_tlast ? ST_PAD : ST_IDLE);
            ST_WRITE:
                if (fill_reg == 6'd63)      state_next = ST_LOAD;
                else if (last_reg)          state_next = ST_PAD;
                else                        state_next = ST_IDLE;
            ST_PAD:     state_next = ST_CLR;
            ST_CLR:
                if (t_reg[3:0] == 4'd15)
                    state_next = second_reg ? ST_LOAD : ST_LEN_HI;
            ST_LEN_HI:  state_next = ST_LEN_LO;
            ST_LEN_LO:  state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_ROUND;
            ST_ROUND:   if (t_reg == 7'd79) state_next = ST_FOLD;
            ST_FOLD:
                if (!fin_reg)               state_next = last_reg ? ST_PAD : ST_IDLE;
                else if (second_reg)        state_next = ST_CLR;
                else                        state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // RAM port control
    always_comb
    begin
        we    = 1'b0;
        waddr = fill_reg[5:2];
        wdata = merged;
        raddr = fill_reg[5:2];
        unique case (state_reg)
            ST_WRITE:  we = 1'b1;
            ST_CLR:
            begin
                // zero words after the pad word; zero all for the extra length block
                we    = (!second_reg && fill_reg >= 6'd56) || (t_reg[3:0] > fill_reg[5:2]);
                waddr = t_reg[3:0];
                wdata = '0;
            end
            ST_PAD:
            begin
                we    = 1'b1;
                wdata = padded;
            end
            ST_LEN_HI:
            begin
                we = 1'b1; waddr = 4'd14; wdata = bits_reg[63:32];
            end
            ST_LEN_LO:
            begin
                we = 1'b1; waddr = 4'd15; wdata = bits_reg[31:0];
            end
            ST_LOAD:   raddr = '0;
            ST_ROUND:  raddr = t_reg[3:0] + 4'd1;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            pres_reg      <= 1'b0;
            last_reg      <= 1'b0;
            second_reg    <= 1'b0;
            fin_reg       <= 1'b0;
            t_reg         <= '0;
            out_valid_reg <= 1'b0;
            h_reg[0] <= H0; h_reg[1] <= H1; h_reg[2] <= H2;
            h_reg[3] <= H3; h_reg[4] <= H4;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        pres_reg <= s_axis_tuser;
                        last_reg <= s_axis_tlast;
                        fin_reg  <= 1'b0;
                    end
                ST_WRITE:
                begin
                    bits_reg <= bits_reg + 64'd8;
                    fill_reg <= fill_reg + 6'd1;
                end
                ST_PAD:
                begin
                    fin_reg    <= 1'b1;
                    second_reg <= (fill_reg >= 6'd56);
                    t_reg      <= '0;
                end
                ST_CLR:
                    t_reg <= (t_reg[3:0] == 4'd15) ? 7'd0 : t_reg + 7'd1;
                ST_LOAD:
                    t_reg <= '0;
                ST_ROUND:
                    t_reg <= t_reg + 7'd1;
                ST_FOLD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    t_reg    <= '0;
                    if (fin_reg && second_reg)
                    begin
                        // extra block: clear all, then length words
                        second_reg <= 1'b0;
                    end
                end
                ST_OUT:
                    // hold the digest in h_reg until the output register frees up
                    if (out_free)
                    begin
                        fill_reg <= '0;
                        bits_reg <= '0;
                        fin_reg  <= 1'b0;
                        h_reg[0] <= H0; h_reg[1] <= H1; h_reg[2] <= H2;
                        h_reg[3] <= H3; h_reg[4] <= H4;
                    end
                default: ;
            endcase
        end
    end

    // payload registers: byte, working variables, schedule window, digest
    always_ff @(posedge clk)
    begin
        if (accept)
            byte_reg <= s_axis_tdata;
        if (state_reg == ST_WRITE)
            wr_word_reg <= merged;
        if (state_reg == ST_LOAD)
        begin
            a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
            d_reg <= h_reg[3]; e_reg <= h_reg[4];
        end
        if (state_reg == ST_ROUND)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= tmp;
            // advance the window by one word
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_cur;
        end
        if (state_reg == ST_OUT && out_free)
            out_reg <= {h_reg[4], h_reg[3], h_reg[2], h_reg[1], h_reg[0]};
    end
endmodule

### src/sha1h_checker.sv
// Port-level checker for the SHA-1 stream hasher, bound to the top level
`include "assert_macros.svh"
module sha1h_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tuser,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata
);
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "digest dropped while stalled")
    `ASSERT_NEXT(a_empty_item, clk, rst_n, s_axis_tvalid && s_axis_tready && !s_axis_tuser && !s_axis_tlast, s_axis_tready, "empty item stalled the input")
    `ASSERT_NEXT(a_last_busy, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "final item did not start padding")
endmodule

bind sha1_stream_hasher_core sha1h_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/tb_sha1_stream_hasher_core.sv
// Testbench for the byte-stream SHA-1 hasher: directed and random messages checked against a local digest model
`timescale 1ns / 1ps

module tb_sha1_stream_hasher_core;
    import sha1h_pkg::*;

    typedef struct packed {
        logic [31:0] word4;
        logic [31:0] word3;
        logic [31:0] word2;
        logic [31:0] word1;
        logic [31:0] word0;
    } digest_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;

    // Hash state mirrored by the predictor
    logic [31:0] chain_h [5];
    logic [31:0] blk_w [16];
    int unsigned fill_n;
    logic [63:0] bit_len;

    digest_t digest_q[$];
    int      err_cnt;
    int      send_idle_pct;
    int      recv_idle_pct;

    sha1_stream_hasher_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),     // [7:0] msg_byte
        .s_axis_tuser(s_axis_tuser),     // [0] byte_present
        .s_axis_tlast(s_axis_tlast),     // end_of_message
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)      // digest_word0 .. digest_word4, lowest first
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] rol(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // Run one 80-round compression of blk_w into chain_h
    task automatic compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = blk_w[i];
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
    endtask

    task automatic put_lane(input int pos, input logic [7:0] v);
        int sh;
        sh = 24 - 8 * (pos % 4);
        blk_w[pos / 4] = (blk_w[pos / 4] & ~(32'hFF << sh)) | (32'(v) << sh);
    endtask

    task automatic restart_hash();
        chain_h[0] = H0; chain_h[1] = H1; chain_h[2] = H2; chain_h[3] = H3; chain_h[4] = H4;
        fill_n = 0;
        bit_len = '0;
    endtask

    // Advance the hash by one accepted transfer; queue a digest on end of message
    task automatic predict_digest(input logic [7:0] data, input logic present, input logic eom);
        digest_t dg;
        if (present)
        begin
            put_lane(fill_n, data);
            bit_len += 64'd8;
            fill_n++;
            if (fill_n == 64)
            begin
                compress_block();
                fill_n = 0;
            end
        end
        if (eom)
        begin
            put_lane(fill_n, PadByte);
            for (int p = fill_n + 1; p < 64; p++)
                put_lane(p, 8'h00);
            if (fill_n >= 56)
            begin
                compress_block();
                for (int p = 0; p < 64; p++)
                    put_lane(p, 8'h00);
            end
            blk_w[14] = bit_len[63:32];
            blk_w[15] = bit_len[31:0];
            compress_block();
            dg.word0 = chain_h[0]; dg.word1 = chain_h[1]; dg.word2 = chain_h[2];
            dg.word3 = chain_h[3]; dg.word4 = chain_h[4];
            digest_q.push_back(dg);
            restart_hash();
        end
    endtask

    // Send one transfer, with random idle cycles before it; valid stays up for the next call
    task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= present;
        s_axis_tlast  <= eom;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_digest(data, present, eom);
    endtask

    task automatic send_message(input int len, input bit byte_on_last);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom), 1'b1, 1'b0);
        send_item(8'($urandom), byte_on_last, 1'b1);
    endtask

    // Random receiver stalls
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each digest transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_q.size() == 0)
            begin
                $display("%0t: unexpected digest %h", $time, m_axis_tdata);
                err_cnt++;
            end
            else
            begin
                digest_t exp_d;
                exp_d = digest_q.pop_front();
                if (m_axis_tdata !== 160'(exp_d))
                begin
                    $display("%0t: digest mismatch expected %h actual %h",
                             $time, 160'(exp_d), m_axis_tdata);
                    err_cnt++;
                end
            end
        end
    end

    // Directed: empty message, single bytes with field extremes, empty items
    task automatic test_edges();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h3C, 1'b0, 1'b1);
    endtask

    // Directed: lengths around the padding and block boundaries
    task automatic test_boundaries();
        send_message(55, 1'b0);
        send_message(55, 1'b1);
        send_message(63, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);
    endtask

    // Random messages, mostly short, some long, with empty items sprinkled in
    task automatic test_random(input int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(70);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(15) == 0)
                begin
                    send_item(8'($urandom), 1'b0, 1'b0);
                    sent++;
                end
                send_item(8'($urandom), 1'b1, 1'b0);
            end
            send_item(8'($urandom), 1'($urandom), 1'b1);
            sent += len + 1;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        err_cnt = 0;
        send_idle_pct = 10;
        recv_idle_pct = 86;
        restart_hash();
        for (int i = 0; i < 16; i++)
            blk_w[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edges();
        test_boundaries();
        test_random(400);
        send_idle_pct = 86;
        recv_idle_pct = 10;
        test_random(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);
        s_axis_tvalid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hold-off limit: well above the slowest correct run
    initial
    begin
        #40ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
